@@ rtl/lru_pkg.sv @@
// shared constants and types for the lru page replacement block
`timescale 1ns / 1ps

package lru_pkg;

    // frame count and stored page width
    localparam int FRAMES    = 4;
    localparam int PAGE_BITS = 8;

    // fixed port widths
    localparam int PAGE_IN_W = 8;
    localparam int EVICT_W   = 8;
    localparam int SLOT_W    = 2;
    localparam int FAULT_W   = 16;

    // derived widths
    localparam int FRAME_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int RANK_W  = FRAME_W;
    localparam int USED_W  = $clog2(FRAMES + 1);

    localparam logic [FAULT_W-1:0] FAULT_MAX = {FAULT_W{1'b1}};

    typedef logic [PAGE_BITS-1:0] page_t;
    typedef logic [FRAME_W-1:0]   frame_idx_t;
    typedef logic [RANK_W-1:0]    rank_t;
    typedef logic [USED_W-1:0]    used_t;

endpackage

@@ rtl/lru_page_replacement.sv @@
// lru page replacement: frame table, recency ranks and fault counter
//
// One page reference per transaction: the caller drives page and raises start;
// the reference is taken at a rising edge with start high and busy low. busy
// stays low, so a reference can be issued in every cycle.
// The reference is captured in an input register, looked up against all frames
// in parallel during the next cycle (frame compare, victim rank compare and
// rank update), and the outcome is registered at the end of that cycle.
// done is high for exactly one cycle with hit, frame_slot, evicted_valid,
// evicted_page and fault_total; that result is taken at the edge ending it.
// Throughput: one reference per cycle, set by the frame compare and rank
// update that loops back into the frame state.
// The receiver cannot stall: results leave on the strobe, nothing is held.
// Reset (rst_n low, asynchronous) empties all frames, clears the ranks, the
// fill count and the fault total, and drops any reference in flight.
// A hit refreshes the frame's recency; a miss fills the next empty frame in
// frame order, or, with all frames full, evicts the least recently used page.
`timescale 1ns / 1ps

module lru_page_replacement
    import lru_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [PAGE_IN_W-1:0] page,
    output logic                 done,
    output logic                 hit,
    output logic [SLOT_W-1:0]    frame_slot,
    output logic                 evicted_valid,
    output logic [EVICT_W-1:0]   evicted_page,
    output logic [FAULT_W-1:0]   fault_total
);

    // input register
    logic  in_valid_reg;
    page_t in_page_reg;
    logic  [PAGE_BITS+PAGE_IN_W-1:0] page_ext;

    // frame state
    page_t        frame_page_reg [FRAMES];
    page_t        frame_page_next[FRAMES];
    rank_t        frame_rank_reg [FRAMES];
    rank_t        frame_rank_next[FRAMES];
    used_t        frames_used_reg;
    used_t        frames_used_next;
    logic [FAULT_W-1:0] fault_count_reg;
    logic [FAULT_W-1:0] fault_count_next;

    // result registers
    logic               done_reg;
    logic               hit_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic               evicted_valid_reg;
    logic [EVICT_W-1:0] evicted_page_reg;

    // lookup signals
    logic       hit_found;
    frame_idx_t hit_idx;
    frame_idx_t victim_idx;
    frame_idx_t slot_idx;
    logic       full;
    logic       promote_all;
    rank_t      limit;
    page_t      victim_page;
    logic [FRAME_W+SLOT_W-1:0]     slot_ext;
    logic [PAGE_BITS+EVICT_W-1:0]  evict_ext;

    assign busy = 1'b0;

    // keep only the low page bits of the port
    assign page_ext = {{PAGE_BITS{1'b0}}, page};

    // capture the reference
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            in_page_reg <= page_ext[PAGE_BITS-1:0];
        end
    end

    // parallel lookup of the resident frames, first match wins
    always_comb
    begin
        hit_found = 1'b0;
        hit_idx   = '0;
        for (int i = 0; i < FRAMES; i++)
        begin
            if (!hit_found && (used_t'(i) < frames_used_reg)
                && (frame_page_reg[i] == in_page_reg))
            begin
                hit_found = 1'b1;
                hit_idx   = frame_idx_t'(i);
            end
        end
    end

    // victim: largest rank, lowest index on a tie
    always_comb
    begin
        victim_idx = '0;
        for (int i = 1; i < FRAMES; i++)
        begin
            if (frame_rank_reg[i] > frame_rank_reg[victim_idx])
            begin
                victim_idx = frame_idx_t'(i);
            end
        end
    end

    assign full        = (frames_used_reg == used_t'(FRAMES));
    assign promote_all = !hit_found;
    assign limit       = frame_rank_reg[hit_idx];
    assign victim_page = frame_page_reg[victim_idx];

    // frame chosen for this reference
    always_comb
    begin
        priority if (hit_found)
        begin
            slot_idx = hit_idx;
        end
        else if (full)
        begin
            slot_idx = victim_idx;
        end
        else
        begin
            slot_idx = frames_used_reg[FRAME_W-1:0];
        end
    end

    // next state of frames, ranks, fill count and fault count
    always_comb
    begin
        frames_used_next = frames_used_reg;
        fault_count_next = fault_count_reg;
        for (int i = 0; i < FRAMES; i++)
        begin
            frame_page_next[i] = frame_page_reg[i];
            frame_rank_next[i] = frame_rank_reg[i];
        end
        if (in_valid_reg)
        begin
            if (!hit_found)
            begin
                if (fault_count_reg != FAULT_MAX)
                begin
                    fault_count_next = fault_count_reg + 1'b1;
                end
                if (!full)
                begin
                    frames_used_next = frames_used_reg + 1'b1;
                end
                frame_page_next[slot_idx] = in_page_reg;
            end
            // age the used frames that were more recent (all of them on a miss), then refresh the slot
            for (int i = 0; i < FRAMES; i++)
            begin
                if ((used_t'(i) < frames_used_next) && (frame_idx_t'(i) != slot_idx)
                    && (promote_all || (frame_rank_reg[i] < limit)))
                begin
                    frame_rank_next[i] = frame_rank_reg[i] + 1'b1;
                end
            end
            frame_rank_next[slot_idx] = '0;
        end
    end

    // narrow the slot and evicted page to the port widths
    assign slot_ext  = {{SLOT_W{1'b0}}, slot_idx};
    assign evict_ext = {{EVICT_W{1'b0}}, victim_page};

    // state registers and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FRAMES; i++)
            begin
                frame_page_reg[i] <= '0;
                frame_rank_reg[i] <= '0;
            end
            frames_used_reg <= '0;
            fault_count_reg <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < FRAMES; i++)
            begin
                frame_page_reg[i] <= frame_page_next[i];
                frame_rank_reg[i] <= frame_rank_next[i];
            end
            frames_used_reg <= frames_used_next;
            fault_count_reg <= fault_count_next;
            done_reg        <= in_valid_reg;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            hit_reg           <= hit_found;
            slot_reg          <= slot_ext[SLOT_W-1:0];
            evicted_valid_reg <= !hit_found && full;
            evicted_page_reg  <= (!hit_found && full) ? evict_ext[EVICT_W-1:0] : '0;
        end
    end

    assign done          = done_reg;
    assign hit           = hit_reg;
    assign frame_slot    = slot_reg;
    assign evicted_valid = evicted_valid_reg;
    assign evicted_page  = evicted_page_reg;
    assign fault_total   = fault_count_reg;

    // checks
    a_done_follows_input: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(in_valid_reg))
        else $error("result strobe without a captured reference");

    a_evict_only_on_fault: assert property (@(posedge clk) disable iff (!rst_n)
        done && evicted_valid |-> !hit && (frames_used_reg == used_t'(FRAMES)))
        else $error("eviction on a hit or with a free frame");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        frames_used_reg <= used_t'(FRAMES))
        else $error("fill count beyond frame count");

    a_fault_counts_misses: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !hit_found && (fault_count_reg != FAULT_MAX)
        |=> fault_count_reg == $past(fault_count_reg) + 1'b1)
        else $error("fault total did not advance on a miss");

    a_hit_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && hit_found |=> $stable(frames_used_reg) && $stable(fault_count_reg))
        else $error("hit changed fill count or fault total");

endmodule

@@ test/lru_checker.sv @@
// lru page replacement checker: frame table predictor and result comparison
`timescale 1ns / 1ps

module lru_checker
    import lru_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  logic [PAGE_IN_W-1:0] page,
    input  logic                 done,
    input  logic                 hit,
    input  logic [SLOT_W-1:0]    frame_slot,
    input  logic                 evicted_valid,
    input  logic [EVICT_W-1:0]   evicted_page,
    input  logic [FAULT_W-1:0]   fault_total,
    output int                   fail_count,
    output int                   pending,
    output int                   hit_count,
    output int                   evict_count
);

    typedef struct packed {
        logic               hit;
        logic [SLOT_W-1:0]  slot;
        logic               evicted;
        logic [EVICT_W-1:0] victim;
        logic [FAULT_W-1:0] faults;
    } outcome_t;

    // predicted frame table
    page_t              resident [FRAMES];
    int                 recency  [FRAMES];
    int                 filled;
    logic [FAULT_W-1:0] fault_tally;

    outcome_t due_outcomes [$];
    int       errors    = 0;
    int       hits_seen = 0;
    int       evicts_seen = 0;

    assign fail_count  = errors;
    assign hit_count   = hits_seen;
    assign evict_count = evicts_seen;

    // move frame f to most recent; used frames more recent than limit age by one
    function automatic void make_recent(int f, int limit);
        for (int i = 0; i < filled; i++)
        begin
            if (i != f && recency[i] < limit)
                recency[i]++;
        end
        recency[f] = 0;
    endfunction

    // look up one page reference and update the predicted frame table
    function automatic outcome_t lru_lookup(logic [PAGE_IN_W-1:0] in_page);
        page_t    pg;
        outcome_t o;
        int       slot;
        int       victim_frame;
        pg = page_t'(in_page);
        o = '0;
        slot = -1;
        for (int i = 0; i < filled; i++)
        begin
            if (slot < 0 && resident[i] == pg)
                slot = i;
        end
        if (slot >= 0)
        begin
            o.hit = 1'b1;
            make_recent(slot, recency[slot]);
        end
        else
        begin
            if (fault_tally != FAULT_MAX)
                fault_tally++;
            if (filled < FRAMES)
            begin
                slot = filled;
                resident[slot] = pg;
                filled++;
                make_recent(slot, 255);
            end
            else
            begin
                // least recently used frame, lowest index on a tie
                victim_frame = 0;
                for (int i = 1; i < FRAMES; i++)
                begin
                    if (recency[i] > recency[victim_frame])
                        victim_frame = i;
                end
                slot = victim_frame;
                o.evicted = 1'b1;
                o.victim = EVICT_W'(resident[slot]);
                resident[slot] = pg;
                make_recent(slot, 255);
            end
        end
        o.slot = SLOT_W'(slot);
        o.faults = fault_tally;
        return o;
    endfunction

    task automatic check_field(input string what, input logic [31:0] expv,
                               input logic [31:0] actv);
        if (expv !== actv)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, what, expv, actv);
        end
    endtask

    // result comparison first, then prediction of any transaction taken at this edge
    always @(posedge clk or negedge rst_n)
    begin : watch
        outcome_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < FRAMES; i++)
            begin
                resident[i] = '0;
                recency[i] = 0;
            end
            filled = 0;
            fault_tally = '0;
            due_outcomes.delete();
            pending <= 0;
        end
        else
        begin
            if (done)
            begin
                if (due_outcomes.size() == 0)
                begin
                    errors++;
                    $display("%0t ns: result with nothing expected, hit %0d slot %0d faults %0d",
                             $time, hit, frame_slot, fault_total);
                end
                else
                begin
                    want = due_outcomes.pop_front();
                    check_field("hit", want.hit, hit);
                    check_field("frame_slot", want.slot, frame_slot);
                    check_field("evicted_valid", want.evicted, evicted_valid);
                    check_field("evicted_page", want.victim, evicted_page);
                    check_field("fault_total", want.faults, fault_total);
                    if (want.hit)
                        hits_seen++;
                    if (want.evicted)
                        evicts_seen++;
                end
            end
            if (start && !busy)
                due_outcomes.push_back(lru_lookup(page));
            pending <= due_outcomes.size();
        end
    end

endmodule

@@ test/tb.sv @@
// testbench top for lru page replacement: clock, reset, reference stimulus, verdict
`timescale 1ns / 1ps

module tb;
    import lru_pkg::*;

    logic                 clk   = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start;
    logic                 busy;
    logic [PAGE_IN_W-1:0] page;
    logic                 done;
    logic                 hit;
    logic [SLOT_W-1:0]    frame_slot;
    logic                 evicted_valid;
    logic [EVICT_W-1:0]   evicted_page;
    logic [FAULT_W-1:0]   fault_total;

    int fail_count;
    int pending;
    int hit_count;
    int evict_count;
    int issued = 0;

    lru_page_replacement DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .page          (page),
        .done          (done),
        .hit           (hit),
        .frame_slot    (frame_slot),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .fault_total   (fault_total)
    );

    lru_checker scoreboard (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .page          (page),
        .done          (done),
        .hit           (hit),
        .frame_slot    (frame_slot),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .fault_total   (fault_total),
        .fail_count    (fail_count),
        .pending       (pending),
        .hit_count     (hit_count),
        .evict_count   (evict_count)
    );

    // 20 ns clock
    always #10 clk = ~clk;

    // hand one page reference over; returns at the edge that takes the transaction
    task automatic issue(input logic [PAGE_IN_W-1:0] pg);
        start <= 1'b1;
        page <= pg;
        do @(posedge clk); while (busy);
        issued++;
    endtask

    // sender gap between transactions
    task automatic pause(input int cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // hold off until every expected result has come back
    task automatic drain();
        start <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // stimulus
    initial
    begin : stimulus
        logic [PAGE_IN_W-1:0] directed [$];
        logic [PAGE_IN_W-1:0] pool [6];
        int                   gap_max;

        start <= 1'b0;
        page <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill with page zero and extremes, hits, evict down to page zero, hit every frame
        directed = '{8'd0, 8'd255, 8'd0, 8'd85, 8'd170, 8'd255, 8'd170, 8'd0,
                     8'd1, 8'd2, 8'd3, 8'd4, 8'd1, 8'd2, 8'd3, 8'd4,
                     8'd0, 8'd128, 8'd127};
        foreach (directed[i])
            issue(directed[i]);
        drain();

        // random references from a small working set, with some stray pages
        for (int blk = 0; blk < 30; blk++)
        begin
            foreach (pool[i])
                pool[i] = PAGE_IN_W'($urandom_range(0, 255));
            gap_max = ($urandom_range(0, 2) == 0) ? 0 : 10;
            for (int n = 0; n < 50; n++)
            begin
                pause($urandom_range(0, gap_max));
                if ($urandom_range(0, 99) < 85)
                    issue(pool[$urandom_range(0, 5)]);
                else
                    issue(PAGE_IN_W'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 7) == 0)
                drain();
        end

        // more traffic from a fresh working set with idle gaps
        foreach (pool[i])
            pool[i] = PAGE_IN_W'($urandom_range(0, 255));
        for (int n = 0; n < 200; n++)
        begin
            pause($urandom_range(0, 10));
            issue(pool[$urandom_range(0, 5)]);
        end

        drain();
        repeat (8) @(posedge clk);

        $display("covered %0d references (%0d hits, %0d evictions), page zero evicted,",
                 issued, hit_count, evict_count);
        $display("back to back references and idle gaps of 0 to 10 cycles");
        if (fail_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    // run limit
    initial
    begin
        #10_000_000;
        $display("tb failed");
        $finish;
    end

endmodule
